@@ design/h2r_pkg.sv @@
// Package for the HSL to RGB converter: widths, fixed-point constants,
// the per-lane segment code and the pipeline control structs.
// No dependencies; every other file in the design depends on it.
package h2r_pkg;

    // Field and internal widths
    localparam int unsigned HUE_W   = 16;
    localparam int unsigned Q_W     = 17;              // Q1.16 level, 65536 = 1.0
    localparam int unsigned POS_W   = 18;              // hue * 3, units of 1/196608 turn
    localparam int unsigned OFF_W   = 16;              // offset into a ramp segment
    localparam int unsigned LS_W    = 2 * Q_W;         // lightness * saturation
    localparam int unsigned RP_W    = Q_W + OFF_W;     // level span * offset
    localparam int unsigned SC_W    = Q_W + 8;         // level * 255
    localparam int unsigned CH_W    = 8;
    localparam int unsigned WORD_W  = 32;

    // Pipeline depth: two front stages, four stages per colour lane
    localparam int unsigned FRONT_N = 2;
    localparam int unsigned LANE_N  = 4;
    localparam int unsigned NSTAGE  = FRONT_N + LANE_N;

    // Shifts
    localparam int unsigned Q_SHIFT    = 16;
    localparam int unsigned RAMP_SHIFT = 15;
    localparam int unsigned CH_SHIFT   = 16;

    typedef logic [HUE_W-1:0] t_hue;
    typedef logic [Q_W-1:0]   t_q;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [OFF_W-1:0] t_off;
    typedef logic [CH_W-1:0]  t_ch;

    // Fixed-point constants
    localparam t_q   Q_ONE      = t_q'(65536);
    localparam t_q   Q_HALF     = t_q'(32768);
    localparam t_pos TURN3      = t_pos'(196608);
    localparam t_pos THIRD3     = t_pos'(65536);
    localparam t_pos TWO_THIRD3 = t_pos'(131072);
    localparam t_pos BRK_SIXTH  = t_pos'(32768);
    localparam t_pos BRK_HALF   = t_pos'(98304);
    localparam t_pos BRK_2THIRD = t_pos'(131072);
    localparam t_ch  ALPHA      = t_ch'(255);

    // Piece of the hue ramp that a position falls in
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    // Stage enables and valid bits handed to the datapath modules
    typedef struct packed {
        logic [FRONT_N-1:0] en;
        logic [FRONT_N-1:0] vld;
    } t_front_ctl;

    typedef struct packed {
        logic [LANE_N-1:0] en;
        logic [LANE_N-1:0] vld;
    } t_lane_ctl;

endpackage

@@ design/h2r_if.sv @@
// Valid/ready channel interfaces of the HSL to RGB converter.
// Depends on h2r_pkg for the field types.
interface h2r_in_if;
    logic              valid;
    logic              ready;
    h2r_pkg::t_hue     hue;
    h2r_pkg::t_q       saturation;
    h2r_pkg::t_q       lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface h2r_out_if;
    logic                            valid;
    logic                            ready;
    logic [h2r_pkg::WORD_W-1:0]      color_word;

    modport source (output valid, output color_word, input ready);
    modport sink   (input valid, input color_word, output ready);
endinterface

@@ design/h2r_front.sv @@
// Front end: clamps saturation and lightness, forms the ramp levels m1, m2
// and their span, and the three hue positions. Two register stages.
// Depends on h2r_pkg.
module h2r_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  h2r_pkg::t_front_ctl i_ctl,
    input  h2r_pkg::t_hue       i_hue,
    input  h2r_pkg::t_q         i_saturation,
    input  h2r_pkg::t_q         i_lightness,
    output h2r_pkg::t_q         o_m1,
    output h2r_pkg::t_q         o_m2,
    output h2r_pkg::t_q         o_d,
    output h2r_pkg::t_pos       o_x_red,
    output h2r_pkg::t_pos       o_x_green,
    output h2r_pkg::t_pos       o_x_blue
);
    import h2r_pkg::*;

    // Stage 1: clamp, product, scaled hue
    t_q              n_s1_l, n_s1_s;
    logic [LS_W-1:0] n_s1_prod;
    t_pos            n_s1_h3;
    t_q              r_s1_l, r_s1_s;
    logic [LS_W-1:0] r_s1_prod;
    t_pos            r_s1_h3;

    always_comb begin
        n_s1_l    = (i_lightness > Q_ONE) ? Q_ONE : i_lightness;
        n_s1_s    = (i_saturation > Q_ONE) ? Q_ONE : i_saturation;
        n_s1_prod = LS_W'(n_s1_l) * LS_W'(n_s1_s);
        n_s1_h3   = POS_W'(i_hue) + (POS_W'(i_hue) << 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s1_l    <= n_s1_l;
            r_s1_s    <= n_s1_s;
            r_s1_prod <= n_s1_prod;
            r_s1_h3   <= n_s1_h3;
        end
    end

    // Stage 2: levels m2 = l + q, m1 = l - q, span 2q; positions wrap at one turn
    t_q   n_p, n_q, n_m1, n_m2, n_d;
    t_pos n_x_red, n_x_blue;
    t_q   r_m1, r_m2, r_d;
    t_pos r_x_red, r_x_green, r_x_blue;

    always_comb begin
        n_p  = r_s1_prod[Q_SHIFT+Q_W-1:Q_SHIFT];
        n_q  = (r_s1_l < Q_HALF) ? n_p : (r_s1_s - n_p);
        n_m2 = r_s1_l + n_q;
        n_m1 = r_s1_l - n_q;
        n_d  = {n_q[Q_W-2:0], 1'b0};
        n_x_red  = (r_s1_h3 >= TWO_THIRD3) ? (r_s1_h3 - TWO_THIRD3) : (r_s1_h3 + THIRD3);
        n_x_blue = (r_s1_h3 >= THIRD3) ? (r_s1_h3 - THIRD3) : (r_s1_h3 + TWO_THIRD3);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_m1      <= n_m1;
            r_m2      <= n_m2;
            r_d       <= n_d;
            r_x_red   <= n_x_red;
            r_x_green <= r_s1_h3;
            r_x_blue  <= n_x_blue;
        end
    end

    assign o_m1      = r_m1;
    assign o_m2      = r_m2;
    assign o_d       = r_d;
    assign o_x_red   = r_x_red;
    assign o_x_green = r_x_green;
    assign o_x_blue  = r_x_blue;

    // Levels stay ordered and within one; positions stay inside one turn
    a_level_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[1] |-> (r_m1 <= r_m2) && (r_m2 <= Q_ONE))
        else $error("front: ramp levels out of order or above one");
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[1] |-> (r_d == t_q'(r_m2 - r_m1)))
        else $error("front: span does not match levels");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[1] |-> (r_x_red < TURN3) && (r_x_green < TURN3) && (r_x_blue < TURN3))
        else $error("front: hue position beyond one turn");

endmodule

@@ design/h2r_lane.sv @@
// One colour lane: picks the ramp segment for a hue position, scales the
// span, forms the level and converts it to an 8-bit channel. Four stages.
// Depends on h2r_pkg.
module h2r_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  h2r_pkg::t_lane_ctl i_ctl,
    input  h2r_pkg::t_q        i_m1,
    input  h2r_pkg::t_q        i_m2,
    input  h2r_pkg::t_q        i_d,
    input  h2r_pkg::t_pos      i_x,
    output h2r_pkg::t_ch       o_channel
);
    import h2r_pkg::*;

    // Stage 1: segment decode and offset into the segment
    t_seg n_l1_seg;
    t_off n_l1_off;
    t_seg r_l1_seg;
    t_off r_l1_off;
    t_q   r_l1_m1, r_l1_m2, r_l1_d;

    always_comb begin
        priority if (i_x < BRK_SIXTH) begin
            n_l1_seg = SEG_RISE;
            n_l1_off = OFF_W'(i_x);
        end else if (i_x < BRK_HALF) begin
            n_l1_seg = SEG_HIGH;
            n_l1_off = '0;
        end else if (i_x < BRK_2THIRD) begin
            n_l1_seg = SEG_FALL;
            n_l1_off = OFF_W'(BRK_2THIRD - i_x);
        end else begin
            n_l1_seg = SEG_LOW;
            n_l1_off = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_l1_seg <= n_l1_seg;
            r_l1_off <= n_l1_off;
            r_l1_m1  <= i_m1;
            r_l1_m2  <= i_m2;
            r_l1_d   <= i_d;
        end
    end

    // Stage 2: span times offset
    logic [RP_W-1:0] r_l2_prod;
    t_seg            r_l2_seg;
    t_q              r_l2_m1, r_l2_m2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_l2_prod <= RP_W'(r_l1_d) * RP_W'(r_l1_off);
            r_l2_seg  <= r_l1_seg;
            r_l2_m1   <= r_l1_m1;
            r_l2_m2   <= r_l1_m2;
        end
    end

    // Stage 3: level on the ramp
    t_q n_l3_slope, n_l3_v;
    t_q r_l3_v;

    always_comb begin
        n_l3_slope = r_l2_prod[RAMP_SHIFT+Q_W-1:RAMP_SHIFT];
        unique case (r_l2_seg)
            SEG_RISE, SEG_FALL: n_l3_v = r_l2_m1 + n_l3_slope;
            SEG_HIGH:           n_l3_v = r_l2_m2;
            SEG_LOW:            n_l3_v = r_l2_m1;
            default:            n_l3_v = r_l2_m1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_l3_v <= n_l3_v;
        end
    end

    // Stage 4: channel = floor(255 * v / 65536), saturated
    logic [SC_W-1:0]          n_l4_scaled;
    logic [SC_W-CH_SHIFT-1:0] n_l4_top;
    t_ch                      n_l4_ch;
    t_ch                      r_channel;

    always_comb begin
        n_l4_scaled = (SC_W'(r_l3_v) << 8) - SC_W'(r_l3_v);
        n_l4_top    = n_l4_scaled[SC_W-1:CH_SHIFT];
        n_l4_ch     = (n_l4_top > (SC_W-CH_SHIFT)'(ALPHA)) ? ALPHA : n_l4_top[CH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_channel <= n_l4_ch;
        end
    end

    assign o_channel = r_channel;

    // A falling segment never starts at zero offset; ramp levels never pass one
    a_fall_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[0] && (r_l1_seg == SEG_FALL) |-> (r_l1_off != '0))
        else $error("lane: falling segment with zero offset");
    a_slope_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[1] && (r_l2_seg == SEG_RISE || r_l2_seg == SEG_FALL)
        |-> (r_l2_prod[RP_W-1:RAMP_SHIFT] <= (RP_W-RAMP_SHIFT)'(r_l2_m2 - r_l2_m1)))
        else $error("lane: slope exceeds level span");
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld[2] |-> (r_l3_v <= Q_ONE))
        else $error("lane: ramp level above one");

endmodule

@@ design/hsl_to_rgb_converter.sv @@
// HSL to RGB converter top level: one colour word per cycle while the output
// is not stalled. 6 register stages (2 front, 4 lane) lie between the input
// handshake and the output word.
// Throughput: one word every cycle; each stage moves on when the stage after
// it is free, so a stall fills bubbles first and drops or repeats nothing.
// Reset (synchronous, active low) clears every stage valid bit; data needs none.
module hsl_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    h2r_in_if.sink      i_in,
    h2r_out_if.source   o_out
);
    import h2r_pkg::*;

    // Stage valid bits and enables
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE-1:0] en;

    always_comb begin
        en[NSTAGE-1] = !r_vld[NSTAGE-1] || o_out.ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_in.valid : r_vld[0];
        for (int k = 1; k < NSTAGE; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Hand enables and valids to the datapath
    t_front_ctl front_ctl;
    t_lane_ctl  lane_ctl;

    assign front_ctl.en  = en[FRONT_N-1:0];
    assign front_ctl.vld = r_vld[FRONT_N-1:0];
    assign lane_ctl.en   = en[NSTAGE-1:FRONT_N];
    assign lane_ctl.vld  = r_vld[NSTAGE-1:FRONT_N];

    t_q   m1, m2, d;
    t_pos x_red, x_green, x_blue;
    t_ch  ch_red, ch_green, ch_blue;

    h2r_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (front_ctl),
        .i_hue        (i_in.hue),
        .i_saturation (i_in.saturation),
        .i_lightness  (i_in.lightness),
        .o_m1         (m1),
        .o_m2         (m2),
        .o_d          (d),
        .o_x_red      (x_red),
        .o_x_green    (x_green),
        .o_x_blue     (x_blue)
    );

    h2r_lane u_lane_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_m1      (m1),
        .i_m2      (m2),
        .i_d       (d),
        .i_x       (x_red),
        .o_channel (ch_red)
    );

    h2r_lane u_lane_green (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_m1      (m1),
        .i_m2      (m2),
        .i_d       (d),
        .i_x       (x_green),
        .o_channel (ch_green)
    );

    h2r_lane u_lane_blue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_m1      (m1),
        .i_m2      (m2),
        .i_d       (d),
        .i_x       (x_blue),
        .o_channel (ch_blue)
    );

    // Pack the output word
    assign i_in.ready       = en[0];
    assign o_out.valid      = r_vld[NSTAGE-1];
    assign o_out.color_word = {ALPHA, ch_blue, ch_green, ch_red};

    // A free output side lets the whole pipe advance
    a_no_stall_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("top: input stalled while output side is free");
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> i_in.ready)
        else $error("top: input stalled with empty first stage");
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("top: accepted word missing from first stage");

endmodule
